// ----- hw/rtl/lkss_pkg.sv -----
// ----------------------------------------------------------------------------
// lkss_pkg
// Shared sizes, codes and types of the lock/key table with scope stack.
// ----------------------------------------------------------------------------
package lkss_pkg;

    localparam int LOCKS           = 128;
    localparam int SCOPE_DEPTH     = 64;

    localparam int LOCK_W          = (LOCKS > 1) ? $clog2(LOCKS) : 1;
    localparam int FC_W            = $clog2(LOCKS + 1);
    localparam int SD_W            = (SCOPE_DEPTH > 1) ? $clog2(SCOPE_DEPTH) : 1;
    localparam int SDC_W           = $clog2(SCOPE_DEPTH + 1);

    localparam int IDX_W           = 7;
    localparam int KEY_W           = 64;
    localparam int CFG_W           = 20;
    localparam int START_KEY_RESET = 100;

    localparam int IN_DATA_W       = 264;
    localparam int OUT_DATA_W      = 80;

    typedef enum logic [2:0] {
        OP_PUSH  = 3'd0,
        OP_POP   = 3'd1,
        OP_ALLOC = 3'd2,
        OP_CHECK = 3'd3,
        OP_FREE  = 3'd4,
        OP_TOP   = 3'd5
    } t_op;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NOFREE   = 3'd1,
        ST_EMPTY    = 3'd2,
        ST_FULL     = 3'd3,
        ST_ZEROKEY  = 3'd4,
        ST_MISMATCH = 3'd5,
        ST_BELOW    = 3'd6,
        ST_ABOVE    = 3'd7
    } t_status;

    typedef struct packed {
        logic [LOCK_W-1:0] lock;
        logic [KEY_W-1:0]  key;
    } t_scope_entry;

    // request index lies inside the lock table
    function automatic logic idx_in_range(logic [IDX_W-1:0] v);
        return int'(v) < LOCKS;
    endfunction

    // stored lock index lies inside the lock table
    function automatic logic lock_in_range(logic [LOCK_W-1:0] v);
        return int'(v) < LOCKS;
    endfunction

    function automatic logic [LOCK_W-1:0] to_lock(logic [IDX_W-1:0] v);
        return LOCK_W'({{LOCK_W{1'b0}}, v});
    endfunction

endpackage

// ----- hw/rtl/lkss_ram.sv -----
// ----------------------------------------------------------------------------
// lkss_ram
// Simple dual-port RAM, one write and one read port, registered read data.
// ----------------------------------------------------------------------------
module lkss_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/lock_key_table_with_scope_stack_unit.sv -----
// ----------------------------------------------------------------------------
// lock_key_table_with_scope_stack_unit
// Lock-and-key temporal safety checker: lock table, free-lock stack, key counter
// and a scope stack of lock/key pairs, one request per cycle unless m_axis stalls.
// ----------------------------------------------------------------------------
// Pipeline: the input register, where a request resolves, then the result register.
// Throughput: one request per cycle while m_axis does not stall; the RAM reads
//   are issued at acceptance.
// Reset: synchronous, active low; resets counters, clears lock used bits and
//   handshake state. No clearing pass: used bits and a low-water mark on the
//   free stack stand in for the reset contents of the tables.
module lock_key_table_with_scope_stack_unit
    import lkss_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    // configuration: first key handed out after the write
    input  logic                  i_cfg_we,
    input  logic [CFG_W-1:0]      i_cfg_wdata,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // index[6:0], key[70:7], pointer[134:71], base[198:135],
    // size[262:199], zero pad [263]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // op[2:0]
    input  logic [2:0]            s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // status[2:0], lock_out[9:3], key_out[73:10], zero pad [79:74]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    // ------------------------------------------------------------------
    // Input register (one request under evaluation)
    // ------------------------------------------------------------------
    logic              r_in_valid;
    t_op               r_in_op;
    logic [IDX_W-1:0]  r_in_index;
    logic [KEY_W-1:0]  r_in_key;
    logic [KEY_W-1:0]  r_in_ptr;
    logic [KEY_W-1:0]  r_in_base;
    logic [KEY_W-1:0]  r_in_size;

    // Result register
    logic              r_out_valid;
    t_status           r_out_status;
    logic [IDX_W-1:0]  r_out_lock;
    logic [KEY_W-1:0]  r_out_key;

    // Table control state
    logic [FC_W-1:0]   r_fc,   n_fc;     // free lock count
    logic [FC_W-1:0]   r_low,  n_low;    // lowest free count seen so far
    logic [SDC_W-1:0]  r_sd,   n_sd;     // scope depth
    logic [KEY_W-1:0]  r_next_key, n_next_key;
    logic [LOCKS-1:0]  r_used, n_used;   // also the valid bits of the key table

    logic fire;      // the request in the input register resolves this cycle
    logic accept;

    assign fire          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // ------------------------------------------------------------------
    // RAM ports
    // ------------------------------------------------------------------
    logic              fs_we;
    logic [LOCK_W-1:0] fs_waddr, fs_raddr, fs_rdata;
    logic [LOCK_W-1:0] fs_wdata;

    logic              sc_we;
    logic [SD_W-1:0]   sc_waddr, sc_raddr;
    t_scope_entry      sc_wdata;
    logic [$bits(t_scope_entry)-1:0] sc_rdata;

    logic              lk_we;
    logic [LOCK_W-1:0] lk_waddr, lk_raddr;
    logic [KEY_W-1:0]  lk_wdata, lk_rdata;

    lkss_ram #(.WIDTH(LOCK_W), .DEPTH(LOCKS)) u_free_stack (
        .i_clk   (i_clk),
        .i_we    (fs_we),
        .i_waddr (fs_waddr),
        .i_wdata (fs_wdata),
        .i_re    (accept),
        .i_raddr (fs_raddr),
        .o_rdata (fs_rdata)
    );

    lkss_ram #(.WIDTH($bits(t_scope_entry)), .DEPTH(SCOPE_DEPTH)) u_scope_stack (
        .i_clk   (i_clk),
        .i_we    (sc_we),
        .i_waddr (sc_waddr),
        .i_wdata (sc_wdata),
        .i_re    (accept),
        .i_raddr (sc_raddr),
        .o_rdata (sc_rdata)
    );

    lkss_ram #(.WIDTH(KEY_W), .DEPTH(LOCKS)) u_lock_keys (
        .i_clk   (i_clk),
        .i_we    (lk_we),
        .i_waddr (lk_waddr),
        .i_wdata (lk_wdata),
        .i_re    (accept),
        .i_raddr (lk_raddr),
        .o_rdata (lk_rdata)
    );

    // Reads for the incoming request use the state as it stands after the
    // request now resolving, so the stack addresses come from the n_ values.
    assign fs_raddr = LOCK_W'(n_fc - FC_W'(1));
    assign sc_raddr = SD_W'(n_sd - SDC_W'(1));
    assign lk_raddr = to_lock(s_axis_tdata[6:0]);

    // One-deep bypass: a write at the same edge as the read would be missed
    // by the RAM, so capture it beside the read.
    logic              r_fs_hit, r_sc_hit, r_lk_hit;
    logic [LOCK_W-1:0] r_fs_bdata;
    t_scope_entry      r_sc_bdata;
    logic [KEY_W-1:0]  r_lk_bdata;
    // Free stack slots below the low-water mark were never written since
    // reset and read as their own position.
    logic              r_fs_init;
    logic [LOCK_W-1:0] r_fs_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fs_hit <= 1'b0;
            r_sc_hit <= 1'b0;
            r_lk_hit <= 1'b0;
        end else if (accept) begin
            r_fs_hit <= fs_we && (fs_waddr == fs_raddr);
            r_sc_hit <= sc_we && (sc_waddr == sc_raddr);
            r_lk_hit <= lk_we && (lk_waddr == lk_raddr);
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_fs_bdata <= fs_wdata;
            r_sc_bdata <= sc_wdata;
            r_lk_bdata <= lk_wdata;
            r_fs_init  <= FC_W'(fs_raddr) < n_low;
            r_fs_addr  <= fs_raddr;
        end
    end

    t_scope_entry      sc_top;
    logic [LOCK_W-1:0] fs_top;
    logic [KEY_W-1:0]  lk_top;

    assign fs_top = r_fs_hit  ? r_fs_bdata :
                    r_fs_init ? r_fs_addr  : fs_rdata;
    assign sc_top = r_sc_hit  ? r_sc_bdata : t_scope_entry'(sc_rdata);
    assign lk_top = r_lk_hit  ? r_lk_bdata : lk_rdata;

    // ------------------------------------------------------------------
    // Key and bounds check
    // ------------------------------------------------------------------
    logic [KEY_W-1:0]  stored_key;
    logic [KEY_W:0]    upper_sum;
    logic [KEY_W-1:0]  upper;
    t_status           chk_status;
    logic [LOCK_W-1:0] req_lock;
    logic              req_ok;

    assign req_lock   = to_lock(r_in_index);
    assign req_ok     = idx_in_range(r_in_index);
    // a lock that is not in use reads as key zero
    assign stored_key = (req_ok && r_used[req_lock]) ? lk_top : '0;
    assign upper_sum  = {1'b0, r_in_base} + {1'b0, r_in_size};
    assign upper      = upper_sum[KEY_W] ? '1 : upper_sum[KEY_W-1:0];   // saturate

    always_comb begin
        if (r_in_key == '0) begin
            chk_status = ST_ZEROKEY;
        end else if (stored_key != r_in_key) begin
            chk_status = ST_MISMATCH;
        end else if (r_in_ptr < r_in_base) begin
            chk_status = ST_BELOW;
        end else if (r_in_ptr > upper) begin
            chk_status = ST_ABOVE;
        end else begin
            chk_status = ST_OK;
        end
    end

    // ------------------------------------------------------------------
    // Request evaluation
    // ------------------------------------------------------------------
    logic [KEY_W-1:0]  stamp_key;
    logic [FC_W-1:0]   fc_dec;
    logic              fc_zero, sd_zero, sd_full, fc_not_full;
    logic              pop_live;

    assign stamp_key   = (r_next_key == '0) ? KEY_W'(1) : r_next_key;   // never hand out zero
    assign fc_dec      = r_fc - FC_W'(1);
    assign fc_zero     = (r_fc == '0);
    assign fc_not_full = (r_fc < FC_W'(LOCKS));
    assign sd_zero     = (r_sd == '0);
    assign sd_full     = (r_sd >= SDC_W'(SCOPE_DEPTH));
    assign pop_live    = lock_in_range(sc_top.lock) && r_used[sc_top.lock];

    t_status           res_status;
    logic [IDX_W-1:0]  res_lock;
    logic [KEY_W-1:0]  res_key;
    logic              stamp;
    logic              rel_en;
    logic [LOCK_W-1:0] rel_lock;

    always_comb begin
        res_status = ST_OK;
        res_lock   = '0;
        res_key    = '0;
        stamp      = 1'b0;
        rel_en     = 1'b0;
        rel_lock   = req_lock;
        sc_we      = 1'b0;
        n_sd       = r_sd;

        if (fire) begin
            case (r_in_op)
                OP_PUSH: begin
                    if (fc_zero) begin
                        res_status = ST_NOFREE;
                    end else if (sd_full) begin
                        res_status = ST_FULL;
                    end else begin
                        stamp = 1'b1;
                        sc_we = 1'b1;
                        n_sd  = r_sd + SDC_W'(1);
                    end
                end
                OP_POP: begin
                    if (sd_zero) begin
                        res_status = ST_EMPTY;
                    end else begin
                        n_sd     = r_sd - SDC_W'(1);
                        res_lock = IDX_W'(sc_top.lock);
                        res_key  = sc_top.key;
                        rel_lock = sc_top.lock;
                        if (pop_live) begin
                            rel_en = 1'b1;
                        end else begin
                            res_status = ST_ZEROKEY;   // lock already freed
                        end
                    end
                end
                OP_ALLOC: begin
                    if (fc_zero) begin
                        res_status = ST_NOFREE;
                    end else begin
                        stamp = 1'b1;
                    end
                end
                OP_CHECK: begin
                    res_status = chk_status;
                end
                OP_FREE: begin
                    res_status = chk_status;
                    rel_en     = (chk_status == ST_OK) && req_ok && r_used[req_lock];
                end
                OP_TOP: begin
                    if (sd_zero) begin
                        res_status = ST_EMPTY;
                    end else begin
                        res_lock = IDX_W'(sc_top.lock);
                        res_key  = sc_top.key;
                    end
                end
                default: begin
                end
            endcase
        end

        if (stamp) begin
            res_lock = IDX_W'(fs_top);
            res_key  = stamp_key;
        end
    end

    assign sc_waddr      = SD_W'(r_sd);
    assign sc_wdata.lock = fs_top;
    assign sc_wdata.key  = stamp_key;

    assign lk_we    = stamp;
    assign lk_waddr = fs_top;
    assign lk_wdata = stamp_key;

    assign fs_we    = rel_en && fc_not_full;
    assign fs_waddr = LOCK_W'(r_fc);
    assign fs_wdata = rel_lock;

    always_comb begin
        n_fc       = r_fc;
        n_low      = r_low;
        n_used     = r_used;
        n_next_key = r_next_key;

        if (stamp) begin
            n_fc             = fc_dec;
            n_low            = (fc_dec < r_low) ? fc_dec : r_low;
            n_used[fs_top]   = 1'b1;
            n_next_key       = stamp_key + KEY_W'(1);
        end
        if (fs_we) begin
            n_fc             = r_fc + FC_W'(1);
            n_used[rel_lock] = 1'b0;
        end
        if (i_cfg_we) begin
            n_next_key = KEY_W'(i_cfg_wdata);
        end
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fc       <= FC_W'(LOCKS);
            r_low      <= FC_W'(LOCKS);
            r_sd       <= '0;
            r_next_key <= KEY_W'(START_KEY_RESET);
            r_used     <= '0;
        end else begin
            r_fc       <= n_fc;
            r_low      <= n_low;
            r_sd       <= n_sd;
            r_next_key <= n_next_key;
            r_used     <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_op    <= t_op'(s_axis_tuser);
            r_in_index <= s_axis_tdata[6:0];
            r_in_key   <= s_axis_tdata[70:7];
            r_in_ptr   <= s_axis_tdata[134:71];
            r_in_base  <= s_axis_tdata[198:135];
            r_in_size  <= s_axis_tdata[262:199];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out_status <= res_status;
            r_out_lock   <= res_lock;
            r_out_key    <= res_key;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'b0, r_out_key, r_out_lock, r_out_status};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_fc_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fc <= FC_W'(LOCKS))
        else $error("free lock count above table size");

    a_low_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low <= r_fc)
        else $error("free stack low-water mark above free count");

    a_sd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sd <= SDC_W'(SCOPE_DEPTH))
        else $error("scope depth above stack size");

    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |=> m_axis_tvalid)
        else $error("resolved request gave no result");
`endif

endmodule

// ----- tb/sv/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the lock/key table with scope stack. It drives
// requests on the input stream with bursty gaps and stalls the result stream
// on its own patterns. An in-bench model of the lock table, free-lock stack,
// key counter and scope stack predicts each result, but for directed rows that
// carry their own. A short table of directed requests runs first, then an
// exhaustion sweep of both stacks, then random traffic under several key seeds.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lkss_pkg::*;

    // op codes the block leaves unused; they must answer ok with zero fields
    localparam logic [2:0] OP_SPARE6 = 3'd6;
    localparam logic [2:0] OP_SPARE7 = 3'd7;

    localparam logic [KEY_W-1:0] ALL_ONES = '1;

    // Pipeline is two registers deep; the settle pause covers the result
    // register draining under a stall.
    localparam int SETTLE_CYCLES = 8;
    // Longest legal stretches without any handshake come from a sender gap, a
    // receiver stall, the settle pause and a config write; the limit lies far
    // beyond their sum.
    localparam int QUIET_LIMIT = 2000;
    localparam int ITEMS_PER_PHASE = 200;

    typedef struct packed {
        logic [2:0]        op;
        logic [IDX_W-1:0]  idx;
        logic [KEY_W-1:0]  key;
        logic [KEY_W-1:0]  ptr;
        logic [KEY_W-1:0]  base;
        logic [KEY_W-1:0]  size;
    } t_req;

    typedef struct packed {
        logic [2:0]        status;
        logic [LOCK_W-1:0] lock;
        logic [KEY_W-1:0]  key;
    } t_verdict;

    typedef enum logic [1:0] {
        RX_STEADY,
        RX_RANDOM,
        RX_PERIODIC
    } t_rx_mode;

    // ---------------------------------------------------------------- DUT I/O
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_W-1:0]      i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // index, key, pointer, base, size, zero pad (lowest bit up)
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    // op
    logic [2:0]            s_axis_tuser  = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // status, lock_out, key_out, zero pad (lowest bit up)
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    lock_key_table_with_scope_stack_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------ lock table model
    logic [KEY_W-1:0]  tbl_key      [LOCKS];
    logic              tbl_used     [LOCKS];
    logic [LOCK_W-1:0] free_lifo    [LOCKS];
    int                free_lvl;
    logic [KEY_W-1:0]  key_ctr;
    logic [LOCK_W-1:0] scope_lock_q [SCOPE_DEPTH];
    logic [KEY_W-1:0]  scope_key_q  [SCOPE_DEPTH];
    int                scope_lvl;

    // results still owed by the block, oldest first
    t_verdict awaited_verdicts [$];

    // directed table
    t_req     dir_req   [$];
    bit       dir_typed [$];
    t_verdict dir_want  [$];

    // bookkeeping
    int       mismatches   = 0;
    int       stray_results = 0;
    int       results_seen = 0;
    int       req_count    = 0;
    int       cfg_writes   = 0;
    int       quiet_cycles = 0;
    int       burst_left   = 0;
    bit       sender_idles = 1'b1;
    t_rx_mode rx_mode      = RX_STEADY;
    int       rx_tick      = 0;
    logic [7:0] ops_seen   = '0;
    logic [7:0] status_seen = '0;
    t_verdict seen_v, want_v;

    function automatic void model_reset();
        int i;
        for (i = 0; i < LOCKS; i++) begin
            tbl_key[i]   = '0;
            tbl_used[i]  = 1'b0;
            free_lifo[i] = LOCK_W'(i);
        end
        for (i = 0; i < SCOPE_DEPTH; i++) begin
            scope_lock_q[i] = '0;
            scope_key_q[i]  = '0;
        end
        free_lvl  = LOCKS;
        key_ctr   = KEY_W'(START_KEY_RESET);
        scope_lvl = 0;
    endfunction

    // take the top free lock and give it a fresh, nonzero key
    function automatic void stamp_lock(output logic [LOCK_W-1:0] lk,
                                       output logic [KEY_W-1:0] ky);
        ky = (key_ctr == '0) ? KEY_W'(1) : key_ctr;
        key_ctr = ky + 1'b1;
        free_lvl--;
        lk = free_lifo[free_lvl];
        tbl_key[lk]  = ky;
        tbl_used[lk] = 1'b1;
    endfunction

    function automatic void release_lock(logic [LOCK_W-1:0] idx);
        if (!tbl_used[idx] || free_lvl >= LOCKS) return;
        tbl_key[idx]  = '0;
        tbl_used[idx] = 1'b0;
        free_lifo[free_lvl] = idx;
        free_lvl++;
    endfunction

    // key test first (zero key = double free), then inclusive bounds with
    // the upper bound saturating at all ones
    function automatic logic [2:0] check_status(t_req r);
        logic [KEY_W:0]   sum;
        logic [KEY_W-1:0] upper;
        logic [KEY_W-1:0] stored;
        sum    = {1'b0, r.base} + {1'b0, r.size};
        upper  = sum[KEY_W] ? ALL_ONES : sum[KEY_W-1:0];
        stored = (int'(r.idx) < LOCKS) ? tbl_key[r.idx] : '0;
        if (r.key == '0)     return ST_ZEROKEY;
        if (stored != r.key) return ST_MISMATCH;
        if (r.ptr < r.base)  return ST_BELOW;
        if (r.ptr > upper)   return ST_ABOVE;
        return ST_OK;
    endfunction

    // expected result of one request; updates the model state
    function automatic t_verdict resolve_request(t_req r);
        t_verdict          v;
        logic [LOCK_W-1:0] lk;
        logic [KEY_W-1:0]  ky;
        v = '0;
        v.status = ST_OK;
        case (r.op)
            OP_PUSH: begin
                if (free_lvl == 0) begin
                    v.status = ST_NOFREE;
                end else if (scope_lvl >= SCOPE_DEPTH) begin
                    v.status = ST_FULL;
                end else begin
                    stamp_lock(lk, ky);
                    scope_lock_q[scope_lvl] = lk;
                    scope_key_q[scope_lvl]  = ky;
                    scope_lvl++;
                    v.lock = lk;
                    v.key  = ky;
                end
            end
            OP_POP: begin
                if (scope_lvl == 0) begin
                    v.status = ST_EMPTY;
                end else begin
                    scope_lvl--;
                    v.lock = scope_lock_q[scope_lvl];
                    v.key  = scope_key_q[scope_lvl];
                    // lock already freed by a check-and-free: report, don't free
                    if (tbl_used[v.lock]) release_lock(v.lock);
                    else v.status = ST_ZEROKEY;
                end
            end
            OP_ALLOC: begin
                if (free_lvl == 0) begin
                    v.status = ST_NOFREE;
                end else begin
                    stamp_lock(lk, ky);
                    v.lock = lk;
                    v.key  = ky;
                end
            end
            OP_CHECK: v.status = check_status(r);
            OP_FREE: begin
                v.status = check_status(r);
                if (v.status == ST_OK) release_lock(to_lock(r.idx));
            end
            OP_TOP: begin
                if (scope_lvl == 0) begin
                    v.status = ST_EMPTY;
                end else begin
                    v.lock = scope_lock_q[scope_lvl-1];
                    v.key  = scope_key_q[scope_lvl-1];
                end
            end
            default: ;
        endcase
        return v;
    endfunction

    // ------------------------------------------------------------ stimulus
    function automatic void add_row(logic [2:0] op, logic [IDX_W-1:0] idx,
                                    logic [KEY_W-1:0] key, logic [KEY_W-1:0] ptr,
                                    logic [KEY_W-1:0] base, logic [KEY_W-1:0] size,
                                    bit typed, logic [2:0] st,
                                    logic [LOCK_W-1:0] lk, logic [KEY_W-1:0] ky);
        t_req     r;
        t_verdict v;
        r = '{op: op, idx: idx, key: key, ptr: ptr, base: base, size: size};
        v = '{status: st, lock: lk, key: ky};
        dir_req.insert(dir_req.size(), r);
        dir_typed.insert(dir_typed.size(), typed);
        dir_want.insert(dir_want.size(), v);
    endfunction

    // Mostly well-formed: checks and frees aim at live locks with their own
    // key and a pointer in or just around the bounds. The rest is noise.
    function automatic t_req random_request();
        t_req             r;
        int               sel;
        int               n;
        int               first;
        bit               found;
        logic [KEY_W:0]   sum;
        logic [KEY_W:0]   span;
        logic [KEY_W:0]   offs;
        logic [KEY_W-1:0] upper;
        sel = $urandom_range(0, 99);
        if      (sel < 14) r.op = OP_PUSH;
        else if (sel < 26) r.op = OP_POP;
        else if (sel < 38) r.op = OP_ALLOC;
        else if (sel < 68) r.op = OP_CHECK;
        else if (sel < 86) r.op = OP_FREE;
        else if (sel < 96) r.op = OP_TOP;
        else r.op = $urandom_range(0, 1) ? OP_SPARE6 : OP_SPARE7;

        r.idx = IDX_W'($urandom);
        found = 1'b0;
        first = $urandom_range(0, LOCKS - 1);
        for (n = 0; n < LOCKS && !found; n++) begin
            if (tbl_used[(first + n) % LOCKS]) begin
                r.idx = IDX_W'((first + n) % LOCKS);
                found = 1'b1;
            end
        end
        if (!found || $urandom_range(0, 9) == 0) r.idx = IDX_W'($urandom);

        sel = $urandom_range(0, 99);
        if (sel < 80)      r.key = tbl_key[r.idx];
        else if (sel < 88) r.key = {$urandom, $urandom};
        else if (sel < 94) r.key = '0;
        else if (sel < 97) r.key = tbl_key[r.idx] + 1'b1;
        else               r.key = tbl_key[r.idx] - 1'b1;

        case ($urandom_range(0, 7))
            0:       r.base = '0;
            1:       r.base = ALL_ONES - KEY_W'($urandom_range(0, 300));
            2, 3:    r.base = {$urandom, $urandom};
            default: r.base = KEY_W'($urandom);
        endcase
        case ($urandom_range(0, 7))
            0:       r.size = '0;
            1:       r.size = ALL_ONES;
            2:       r.size = {$urandom, $urandom};
            default: r.size = KEY_W'($urandom_range(0, 4096));
        endcase
        sum   = {1'b0, r.base} + {1'b0, r.size};
        upper = sum[KEY_W] ? ALL_ONES : sum[KEY_W-1:0];

        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            span  = {1'b0, upper} - {1'b0, r.base} + 1'b1;
            offs  = {1'b0, $urandom, $urandom} % span;
            r.ptr = r.base + offs[KEY_W-1:0];
        end
        else if (sel < 70) r.ptr = r.base;
        else if (sel < 80) r.ptr = upper;
        else if (sel < 88) r.ptr = r.base - 1'b1;
        else if (sel < 96) r.ptr = upper + 1'b1;
        else               r.ptr = {$urandom, $urandom};
        return r;
    endfunction

    // One request on the input stream. The model is advanced at the edge
    // that accepts it, so the next random request sees the updated tables.
    task automatic send_req(t_req r, bit typed, t_verdict want);
        t_verdict v;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            if (sender_idles) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 6)) @(negedge i_clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= r.op;
        s_axis_tdata  <= {1'b0, r.size, r.base, r.ptr, r.key, r.idx};
        do @(posedge i_clk); while (!s_axis_tready);
        v = resolve_request(r);
        awaited_verdicts.insert(awaited_verdicts.size(), typed ? want : v);
        req_count++;
        ops_seen[r.op] = 1'b1;
        status_seen[v.status] = 1'b1;
        @(negedge i_clk);
    endtask

    task automatic send_op(logic [2:0] op);
        t_req r;
        r    = random_request();
        r.op = op;
        send_req(r, 1'b0, '0);
    endtask

    // hold off the sender until every owed result is back, then let the
    // pipeline settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (awaited_verdicts.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_key_seed(logic [CFG_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        key_ctr = KEY_W'(v);
        cfg_writes++;
    endtask

    // --------------------------------------------------------------- receiver
    always @(negedge i_clk) begin
        rx_tick <= rx_tick + 1;
        case (rx_mode)
            RX_STEADY: m_axis_tready <= 1'b1;
            RX_RANDOM: m_axis_tready <= ($urandom_range(0, 3) != 0);
            default:   m_axis_tready <= ((rx_tick % 9) < 6);
        endcase
    end

    // ---------------------------------------------------- result checking
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen_v.status = m_axis_tdata[2:0];
            seen_v.lock   = m_axis_tdata[9:3];
            seen_v.key    = m_axis_tdata[73:10];
            results_seen++;
            if (awaited_verdicts.size() == 0) begin
                stray_results++;
                if (mismatches + stray_results <= 10)
                    $display("[%0t] unexpected result: status %0d lock %0d key %h",
                             $realtime, seen_v.status, seen_v.lock, seen_v.key);
            end else begin
                want_v = awaited_verdicts.pop_front();
                if (seen_v.status !== want_v.status || seen_v.lock !== want_v.lock ||
                    seen_v.key !== want_v.key) begin
                    mismatches++;
                    if (mismatches + stray_results <= 10) begin
                        $write("[%0t] result %0d: expected status %0d lock %0d key %h,",
                               $realtime, results_seen, want_v.status, want_v.lock,
                               want_v.key);
                        $display(" got status %0d lock %0d key %h",
                                 seen_v.status, seen_v.lock, seen_v.key);
                    end
                end
            end
        end
    end

    // watchdog: cycles in which neither stream moves
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("[%0t] no handshake for %0d cycles, %0d results owed",
                         $realtime, QUIET_LIMIT, awaited_verdicts.size());
                $display("Some tests failed");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------ main flow
    initial begin
        int       row;
        int       ph;
        int       i;
        t_req     r;
        logic [CFG_W-1:0] sk;

        model_reset();
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed table, key seed at its reset value 100. Free stack top
        // is lock 127, so the first allocations are 127 then 126.
        add_row(OP_POP,   0, 0, 0, 0, 0, 1'b1, ST_EMPTY, 0, 0);
        add_row(OP_TOP,   0, 0, 0, 0, 0, 1'b1, ST_EMPTY, 0, 0);
        add_row(OP_ALLOC, 0, 0, 0, 0, 0, 1'b1, ST_OK, 127, 100);
        add_row(OP_PUSH,  0, 0, 0, 0, 0, 1'b1, ST_OK, 126, 101);
        add_row(OP_TOP,   0, 0, 0, 0, 0, 1'b1, ST_OK, 126, 101);
        // double-free marker: zero key
        add_row(OP_CHECK, 127, 0, 0, 0, 0, 1'b1, ST_ZEROKEY, 0, 0);
        add_row(OP_CHECK, 127, 100, 0, 1, 0, 1'b1, ST_BELOW, 0, 0);
        add_row(OP_CHECK, 127, 100, ALL_ONES, 0, 5, 1'b1, ST_ABOVE, 0, 0);
        // base + size overflows and saturates, so all ones is in bounds
        add_row(OP_CHECK, 127, 100, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, ST_OK, 0, 0);
        add_row(OP_CHECK, 127, 100, 7, 7, 0, 1'b1, ST_OK, 0, 0);
        add_row(OP_CHECK, 127, 99, 7, 7, 0, 1'b1, ST_MISMATCH, 0, 0);
        add_row(OP_CHECK, 0, ALL_ONES, 0, 0, 0, 1'b1, ST_MISMATCH, 0, 0);
        add_row(OP_CHECK, 126, 101, 'h1010, 'h1000, 'h10, 1'b0, ST_OK, 0, 0);
        // free the scope lock behind the scope stack's back
        add_row(OP_FREE,  126, 101, 'h1010, 'h1000, 'h10, 1'b0, ST_OK, 0, 0);
        // pop of a scope lock already freed: reported, not freed again
        add_row(OP_POP,   0, 0, 0, 0, 0, 1'b1, ST_ZEROKEY, 126, 101);
        add_row(OP_FREE,  127, 100, 0, 0, 0, 1'b0, ST_OK, 0, 0);
        add_row(OP_FREE,  127, 100, 0, 0, 0, 1'b1, ST_MISMATCH, 0, 0);
        add_row(OP_CHECK, 127, 100, 0, 0, 0, 1'b1, ST_MISMATCH, 0, 0);
        add_row(OP_ALLOC, 0, 0, 0, 0, 0, 1'b0, ST_OK, 0, 0);
        // failed free must leave the lock live
        add_row(OP_FREE,  127, 102, 10, 0, 9, 1'b1, ST_ABOVE, 0, 0);
        add_row(OP_FREE,  127, 102, ALL_ONES, ALL_ONES, 0, 1'b0, ST_OK, 0, 0);
        add_row(OP_SPARE6, 127, ALL_ONES, 0, 0, 0, 1'b1, ST_OK, 0, 0);
        add_row(OP_SPARE7, 0, 0, ALL_ONES, ALL_ONES, ALL_ONES, 1'b1, ST_OK, 0, 0);

        rx_mode      = RX_PERIODIC;
        sender_idles = 1'b1;
        for (row = 0; row < dir_req.size(); row++)
            send_req(dir_req[row], dir_typed[row], dir_want[row]);

        // Exhaustion sweep at the lowest key seed: fill the scope stack past
        // full, drain the free stack past empty, then unwind everything.
        wait_drained();
        write_key_seed(CFG_W'(1));
        rx_mode      = RX_RANDOM;
        sender_idles = 1'b0;
        repeat (SCOPE_DEPTH + 1) send_op(OP_PUSH);
        while (free_lvl > 0) send_op(OP_ALLOC);
        send_op(OP_ALLOC);
        send_op(OP_PUSH);
        send_op(OP_TOP);
        repeat (SCOPE_DEPTH + 1) send_op(OP_POP);
        for (i = 0; i < LOCKS; i++) begin
            if (tbl_used[i]) begin
                r      = random_request();
                r.op   = OP_FREE;
                r.idx  = IDX_W'(i);
                r.key  = tbl_key[i];
                r.ptr  = r.base;
                send_req(r, 1'b0, '0);
            end
        end

        // Random traffic, one key seed and one flow-control shape per phase.
        for (ph = 0; ph < 4; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    sk = CFG_W'(1000000);
                    rx_mode = RX_RANDOM;
                    sender_idles = 1'b1;
                end
                1: begin
                    sk = CFG_W'($urandom_range(1, 1000000));
                    rx_mode = RX_STEADY;
                    sender_idles = 1'b0;
                end
                2: begin
                    sk = CFG_W'($urandom_range(1, 1000000));
                    rx_mode = RX_PERIODIC;
                    sender_idles = 1'b1;
                end
                default: begin
                    sk = CFG_W'($urandom_range(1, 1000000));
                    rx_mode = RX_RANDOM;
                    sender_idles = 1'b1;
                end
            endcase
            write_key_seed(sk);
            repeat (ITEMS_PER_PHASE) begin
                send_req(random_request(), 1'b0, '0);
                if ($urandom_range(0, 99) == 0) wait_drained();
            end
        end

        wait_drained();

        $display("Run: %0d requests, %0d results, %0d key seed writes, ops seen %b",
                 req_count, results_seen, cfg_writes, ops_seen);
        $display("     statuses seen %b, %0d mismatches, %0d unexpected results",
                 status_seen, mismatches, stray_results);
        if (mismatches == 0 && stray_results == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
